/* rtl/svrm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// svrm_pkg
// Shared types and constants of the stereo volume ramp mixer.
// ----------------------------------------------------------------------------
package svrm_pkg;

	localparam int GAIN_ENTRIES = 128;
	localparam int GIDX_W       = $clog2(GAIN_ENTRIES);

	localparam int VOL_W       = 32;
	localparam int VOL_FRAC_W  = 24;
	localparam int VOL_INT_W   = 7;
	localparam int RAMP_W      = 21;
	localparam int FRAME_SHIFT = 5;

	localparam logic [VOL_INT_W-1:0] VOL_MAX    = 7'h7f;
	localparam logic [15:0]          FRAMES_MAX = 16'd60000;

	localparam int DVD_W = VOL_W + 1 - FRAME_SHIFT;
	localparam int DVS_W = 16;

	typedef enum logic [1:0] {
		KIND_MIX  = 2'd0,
		KIND_FADE = 2'd1,
		KIND_LOAD = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic                movie_valid;
		logic signed [15:0]  movie_left;
		logic signed [15:0]  movie_right;
		logic signed [15:0]  dry_left;
		logic signed [15:0]  dry_right;
		logic                block_end;
		logic signed [15:0]  fade_volume;
		logic [15:0]         fade_frames;
		logic [6:0]          table_index;
		logic [15:0]         table_value;
	} item_t;

	typedef struct packed {
		logic signed [15:0] out_left;
		logic signed [15:0] out_right;
		logic               last_in_block;
		logic               accepted;
	} result_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

endpackage
`default_nettype wire

/* rtl/svrm_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// svrm_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface svrm_item_if;
	import svrm_pkg::*;
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface svrm_result_if;
	import svrm_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/svrm_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// svrm_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module svrm_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire svrm_pkg::div_req_t req,
	output svrm_pkg::div_rsp_t      rsp
);
	import svrm_pkg::*;

	localparam int DCNT_W = $clog2(DVD_W);

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVD_W-1:0]  quo_q;

	logic [DVS_W:0]   shifted;
	logic [DVS_W+1:0] trial;

	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DVD_W - 1);
				rem_q  <= '0;
				dvs_q  <= req.divisor;
				quo_q  <= req.dividend;
			end else if (busy_q) begin
				if (trial[DVS_W+1]) begin
					rem_q <= shifted[DVS_W-1:0];
					quo_q <= {quo_q[DVD_W-2:0], 1'b0};
				end else begin
					rem_q <= trial[DVS_W-1:0];
					quo_q <= {quo_q[DVD_W-2:0], 1'b1};
				end
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
`default_nettype wire

/* rtl/stereo_volume_ramp_mixer_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_volume_ramp_mixer_top
// Mixes a gained movie sample pair into a dry pair under a volume ramp.
// ----------------------------------------------------------------------------
// Usage:
//   item   - request channel (valid/ready): mix, fade or gain table load.
//   result - one result per request (valid/ready), in request order.
//   cfg_we/cfg_wdata - audio_present register, written while idle.
// One request is in flight at a time. A mix request with a movie sample
// passes through the gain RAM read, multiply, add and saturate into the
// result register, then into the output register. Mix requests without a
// movie sample, loads, zero-length and refused fades and the unused kind
// go straight to the result register. A fade with nonzero length first
// runs the 28-bit step divide, one quotient bit per cycle.
// The next request is accepted as soon as the result moves into the output
// register, even if the receiver has not taken it yet.
// When the receiver stalls with a full output register, the block holds
// the next result internally and stops accepting.
// Reset clears volume, target, ramp and step to zero and audio_present to
// 0. The gain table is not cleared; entries must be loaded before use.
// ----------------------------------------------------------------------------
module stereo_volume_ramp_mixer_top (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_we,
	input  wire logic     cfg_wdata,
	svrm_item_if.sink     item,
	svrm_result_if.source result
);
	import svrm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GAIN,
		ST_SUM,
		ST_DIV,
		ST_HOLD
	} state_t;

	state_t              state_q;
	logic                audio_q;
	logic [VOL_W-1:0]    cur_q;
	logic [VOL_W-1:0]    step_q;
	logic [VOL_INT_W-1:0] tgt_q;
	logic [RAMP_W-1:0]   ramp_q;
	logic                neg_q;

	logic signed [15:0]  movie_l_s1;
	logic signed [15:0]  movie_r_s1;
	logic signed [15:0]  dry_l_s1;
	logic signed [15:0]  dry_r_s1;
	logic                last_s1;
	logic signed [32:0]  prod_l_s2;
	logic signed [32:0]  prod_r_s2;

	result_t             res_q;
	result_t             out_q;
	logic                out_valid_q;

	logic [15:0]         gain_mem [GAIN_ENTRIES];
	logic [15:0]         gain_rd_q;

	item_t               d;
	logic                accept;
	logic                mix_movie;
	logic [VOL_W-1:0]    cur_next;
	logic [31:0]         int32;
	logic [GIDX_W-1:0]   rd_addr;
	logic                mem_re;
	logic [31:0]         load_idx32;
	logic                mem_we;
	logic [VOL_INT_W-1:0] fade_vol;
	logic [15:0]         fade_frames_c;
	logic [32:0]         diff;
	logic [32:0]         abs_diff;
	logic                out_free;
	logic signed [18:0]  sum_l;
	logic signed [18:0]  sum_r;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
		if (v > 19'sd32767) begin
			return 16'sh7fff;
		end else if (v < -19'sd32768) begin
			return 16'sh8000;
		end else begin
			return v[15:0];
		end
	endfunction

	assign d           = item.data;
	assign item.ready  = (state_q == ST_IDLE);
	assign accept      = item.valid && item.ready;
	assign mix_movie   = d.movie_valid && audio_q;

	assign cur_next = (ramp_q != '0) ? cur_q + step_q : {1'b0, tgt_q, {VOL_FRAC_W{1'b0}}};
	assign int32    = cur_next[VOL_W-1] ? 32'd0 : 32'(cur_next[VOL_W-2:VOL_FRAC_W]);
	assign rd_addr  = (int32 > 32'(GAIN_ENTRIES - 1)) ? GIDX_W'(GAIN_ENTRIES - 1)
	                                                  : int32[GIDX_W-1:0];
	assign mem_re   = accept && (d.kind == KIND_MIX) && mix_movie;

	assign load_idx32 = 32'(d.table_index);
	assign mem_we     = accept && (d.kind == KIND_LOAD) && (load_idx32 < 32'(GAIN_ENTRIES));

	assign fade_vol = d.fade_volume[15] ? '0 :
	                  (d.fade_volume > 16'sd127) ? VOL_MAX : d.fade_volume[VOL_INT_W-1:0];
	assign fade_frames_c = (d.fade_frames > FRAMES_MAX) ? FRAMES_MAX : d.fade_frames;
	assign diff     = {2'b00, fade_vol, {VOL_FRAC_W{1'b0}}} - {cur_q[VOL_W-1], cur_q};
	assign abs_diff = diff[32] ? (33'd0 - diff) : diff;

	assign div_req.start    = accept && (d.kind == KIND_FADE) && audio_q &&
	                          (fade_frames_c != '0);
	assign div_req.dividend = abs_diff[32:FRAME_SHIFT];
	assign div_req.divisor  = fade_frames_c;

	assign sum_l = {{3{dry_l_s1[15]}}, dry_l_s1} + {prod_l_s2[32], prod_l_s2[32:15]};
	assign sum_r = {{3{dry_r_s1[15]}}, dry_r_s1} + {prod_r_s2[32], prod_r_s2[32:15]};

	assign out_free = !out_valid_q || result.ready;

	svrm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			gain_mem[load_idx32[GIDX_W-1:0]] <= d.table_value;
		end
		if (mem_re) begin
			gain_rd_q <= gain_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			audio_q     <= 1'b0;
			cur_q       <= '0;
			step_q      <= '0;
			tgt_q       <= '0;
			ramp_q      <= '0;
			neg_q       <= 1'b0;
			movie_l_s1  <= '0;
			movie_r_s1  <= '0;
			dry_l_s1    <= '0;
			dry_r_s1    <= '0;
			last_s1     <= 1'b0;
			prod_l_s2   <= '0;
			prod_r_s2   <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				audio_q <= cfg_wdata;
			end
			if (out_valid_q && result.ready && (state_q != ST_HOLD)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_HOLD;
						case (d.kind)
							KIND_MIX: begin
								if (mix_movie) begin
									cur_q      <= cur_next;
									if (ramp_q != '0) begin
										ramp_q <= ramp_q - 1'b1;
									end
									movie_l_s1 <= d.movie_left;
									movie_r_s1 <= d.movie_right;
									dry_l_s1   <= d.dry_left;
									dry_r_s1   <= d.dry_right;
									last_s1    <= d.block_end;
									state_q    <= ST_GAIN;
								end else begin
									res_q <= {d.dry_left, d.dry_right, d.block_end, 1'b0};
								end
							end
							KIND_FADE: begin
								if (audio_q) begin
									tgt_q <= fade_vol;
									if (fade_frames_c != '0) begin
										ramp_q  <= {fade_frames_c, {FRAME_SHIFT{1'b0}}};
										neg_q   <= diff[32];
										res_q   <= '0;
										state_q <= ST_DIV;
									end else begin
										ramp_q <= '0;
										cur_q  <= {1'b0, fade_vol, {VOL_FRAC_W{1'b0}}};
										res_q  <= {16'd0, 16'd0, 1'b0, 1'b1};
									end
								end else begin
									res_q <= '0;
								end
							end
							default: begin
								res_q <= '0;
							end
						endcase
					end
				end
				ST_GAIN: begin
					prod_l_s2 <= $signed({1'b0, gain_rd_q}) * movie_l_s1;
					prod_r_s2 <= $signed({1'b0, gain_rd_q}) * movie_r_s1;
					state_q   <= ST_SUM;
				end
				ST_SUM: begin
					res_q   <= {sat16(sum_l), sat16(sum_r), last_s1, 1'b0};
					state_q <= ST_HOLD;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						step_q         <= neg_q ? (32'd0 - 32'(div_rsp.quotient))
						                        : 32'(div_rsp.quotient);
						res_q.accepted <= 1'b1;
						state_q        <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

endmodule
`default_nettype wire

/* rtl/svrm_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// svrm_checker
// Port-level checks of the stereo volume ramp mixer, bound to the top level.
// ----------------------------------------------------------------------------
module svrm_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire svrm_pkg::result_t out_data
);
	import svrm_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while one is in flight");

	a_fade_result_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.accepted |->
			out_data.out_left == 16'sd0 && out_data.out_right == 16'sd0 &&
			!out_data.last_in_block)
		else $error("fade result carries sample data");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && in_valid && in_ready |=> !out_valid)
		else $error("result appeared one cycle after request");

endmodule

bind stereo_volume_ramp_mixer_top svrm_checker u_svrm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);
`default_nettype wire

/* verif/tb_stereo_volume_ramp_mixer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_volume_ramp_mixer_top
// Self-checking bench for the stereo volume ramp mixer. It fills the gain
// table, runs directed requests for saturation, clamping, refused fades and
// the unused kind, and then runs random request traffic under three stall
// profiles. Each result is checked field by field against an in-bench
// model of the volume ramp and the saturating mix.
// ----------------------------------------------------------------------------
module tb_stereo_volume_ramp_mixer_top;
	import svrm_pkg::*;

	localparam logic [1:0] KIND_UNUSED  = 2'd3;
	localparam int         STALL_LIMIT  = 2000;
	localparam int         DRAIN_CYCLES = 40;
	localparam int         PRINT_LIMIT  = 50;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	logic sink_take = 1'b0;

	svrm_item_if   item_ch ();
	svrm_result_if result_ch ();

	assign result_ch.ready = sink_take;

	stereo_volume_ramp_mixer_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.result    (result_ch)
	);

	logic [15:0]          gain_tab [GAIN_ENTRIES];
	logic [VOL_W-1:0]     cur_vol;
	logic [VOL_INT_W-1:0] tgt_vol;
	logic [RAMP_W-1:0]    ramp_left;
	logic [VOL_W-1:0]     vol_step;
	bit                   audio_on;

	result_t mix_out_fifo [$];

	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int err_count = 0;
	int req_count = 0;
	int checked_count = 0;
	int fades_taken = 0;
	int ramp_steps = 0;
	int sat_count = 0;
	int idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic flag_mismatch(string msg);
		err_count++;
		if (err_count <= PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	function automatic logic [15:0] mix_chan(logic [15:0] gain, logic signed [15:0] movie,
		logic signed [15:0] dry);
		longint acc;
		acc = longint'(dry) + ((longint'(gain) * longint'(movie)) >>> 15);
		if (acc > 32767) begin
			sat_count++;
			return 16'h7fff;
		end
		if (acc < -32768) begin
			sat_count++;
			return 16'h8000;
		end
		return acc[15:0];
	endfunction

	function automatic result_t predict_mix_out(item_t it);
		result_t     r;
		longint      lvl;
		longint      diff;
		longint      span;
		longint      quo;
		int          gidx;
		logic [15:0] gain;
		logic [15:0] frames;
		r = '0;
		case (it.kind)
		KIND_MIX: begin
			if (it.movie_valid && audio_on) begin
				if (ramp_left != 0) begin
					ramp_left = ramp_left - 1'b1;
					cur_vol = cur_vol + vol_step;
					ramp_steps++;
				end else begin
					cur_vol = {1'b0, tgt_vol, 24'b0};
				end
				if ($signed(cur_vol) < 0)
					gidx = 0;
				else
					gidx = int'($signed(cur_vol) >>> VOL_FRAC_W);
				if (gidx > GAIN_ENTRIES - 1)
					gidx = GAIN_ENTRIES - 1;
				gain = gain_tab[gidx];
				r.out_left  = mix_chan(gain, it.movie_left, it.dry_left);
				r.out_right = mix_chan(gain, it.movie_right, it.dry_right);
			end else begin
				r.out_left  = it.dry_left;
				r.out_right = it.dry_right;
			end
			r.last_in_block = it.block_end;
		end
		KIND_FADE: begin
			if (audio_on) begin
				lvl = longint'(it.fade_volume);
				if (lvl > longint'(VOL_MAX))
					lvl = longint'(VOL_MAX);
				if (lvl < 0)
					lvl = 0;
				frames = (it.fade_frames > FRAMES_MAX) ? FRAMES_MAX : it.fade_frames;
				tgt_vol = lvl[VOL_INT_W-1:0];
				if (frames != 0) begin
					span = longint'(frames) << FRAME_SHIFT;
					diff = (lvl << VOL_FRAC_W) - longint'($signed(cur_vol));
					quo = diff / span;
					ramp_left = span[RAMP_W-1:0];
					vol_step = quo[VOL_W-1:0];
				end else begin
					ramp_left = '0;
					quo = lvl << VOL_FRAC_W;
					cur_vol = quo[VOL_W-1:0];
				end
				r.accepted = 1'b1;
				fades_taken++;
			end
		end
		KIND_LOAD: begin
			gain_tab[it.table_index] = it.table_value;
		end
		default: begin
		end
		endcase
		return r;
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 15))
		0: return 16'h7fff;
		1: return 16'h8000;
		2: return 16'h0000;
		3: return 16'hffff;
		default: return 16'($urandom);
		endcase
	endfunction

	function automatic item_t random_request();
		item_t it;
		int    pick;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			it.kind = KIND_MIX;
		else if (pick < 82)
			it.kind = KIND_FADE;
		else if (pick < 97)
			it.kind = KIND_LOAD;
		else
			it.kind = KIND_UNUSED;
		it.movie_valid = ($urandom_range(0, 9) != 0);
		it.movie_left  = pick_sample();
		it.movie_right = pick_sample();
		it.dry_left    = pick_sample();
		it.dry_right   = pick_sample();
		it.block_end   = ($urandom_range(0, 7) == 0);
		it.fade_volume = ($urandom_range(0, 3) == 0) ? pick_sample()
		                                             : 16'($urandom_range(0, 127));
		case ($urandom_range(0, 9))
		0, 1, 2, 3, 4: it.fade_frames = 16'd1;
		5, 6: it.fade_frames = 16'd0;
		7: it.fade_frames = 16'($urandom_range(2, 3));
		default: it.fade_frames = 16'($urandom);
		endcase
		it.table_index = 7'($urandom);
		it.table_value = pick_sample();
		return it;
	endfunction

	function automatic item_t mk_mix(logic mv, logic [15:0] ml, logic [15:0] mr,
		logic [15:0] dl, logic [15:0] dr, logic be);
		item_t it;
		it = random_request();
		it.kind        = KIND_MIX;
		it.movie_valid = mv;
		it.movie_left  = ml;
		it.movie_right = mr;
		it.dry_left    = dl;
		it.dry_right   = dr;
		it.block_end   = be;
		return it;
	endfunction

	function automatic item_t mk_fade(logic [15:0] vol, logic [15:0] frames);
		item_t it;
		it = random_request();
		it.kind        = KIND_FADE;
		it.fade_volume = vol;
		it.fade_frames = frames;
		return it;
	endfunction

	function automatic item_t mk_load(logic [6:0] idx, logic [15:0] val);
		item_t it;
		it = random_request();
		it.kind        = KIND_LOAD;
		it.table_index = idx;
		it.table_value = val;
		return it;
	endfunction

	task automatic send_request(item_t it);
		if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < src_idle_pct)
				@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		@(posedge clk);
		while (item_ch.ready !== 1'b1)
			@(posedge clk);
		mix_out_fifo.push_back(predict_mix_out(it));
		req_count++;
	endtask

	task automatic drain_results();
		item_ch.valid <= 1'b0;
		while (mix_out_fifo.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_audio_present(logic on);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= on;
		@(posedge clk);
		cfg_we <= 1'b0;
		audio_on = on;
	endtask

	task automatic test_gain_table_load();
		logic [15:0] val;
		for (int i = 0; i < GAIN_ENTRIES; i++) begin
			if (i == 0)
				val = 16'h8000;
			else if (i == GAIN_ENTRIES - 1)
				val = 16'hffff;
			else if (i == GAIN_ENTRIES / 2)
				val = 16'h0000;
			else
				val = pick_sample();
			send_request(mk_load(7'(i), val));
		end
	endtask

	task automatic test_audio_off();
		send_request(mk_mix(1'b1, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b1));
		send_request(mk_fade(16'd127, 16'd0));
		send_request(mk_fade(16'h7fff, 16'hffff));
		send_request(mk_load(7'd1, 16'h1234) ^ '0);
	endtask

	task automatic test_volume_jump();
		send_request(mk_fade(16'd127, 16'd0));
		send_request(mk_mix(1'b1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0));
		send_request(mk_mix(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1));
		send_request(mk_mix(1'b1, 16'hffff, 16'h0001, 16'h0000, 16'h0000, 1'b0));
		send_request(mk_mix(1'b0, 16'h1234, 16'h5678, 16'h8000, 16'h7fff, 1'b1));
	endtask

	task automatic test_fade_clamps();
		send_request(mk_fade(16'h8000, 16'hffff));
		send_request(mk_mix(1'b1, 16'h4000, 16'hc000, 16'h0100, 16'hff00, 1'b0));
		send_request(mk_fade(16'h7fff, 16'd1));
		send_request(mk_mix(1'b1, 16'h7fff, 16'h8000, 16'h0000, 16'h0000, 1'b0));
		send_request(mk_mix(1'b1, 16'h0001, 16'hffff, 16'h0000, 16'h0000, 1'b1));
		send_request(mk_fade(16'd0, 16'd0));
		send_request(mk_mix(1'b1, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 1'b0));
	endtask

	task automatic test_reload_and_unused_kind();
		item_t it;
		send_request(mk_load(7'd0, 16'hffff));
		send_request(mk_mix(1'b1, 16'h4000, 16'hc000, 16'h0000, 16'h0000, 1'b1));
		it = random_request();
		it.kind = KIND_UNUSED;
		send_request(it);
	endtask

	task automatic test_random_traffic(int count);
		for (int i = 0; i < count; i++)
			send_request(random_request());
	endtask

	always @(posedge clk) begin
		sink_take <= ($urandom_range(0, 99) >= snk_idle_pct);
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (mix_out_fifo.size() == 0) begin
				flag_mismatch("result with no request pending");
			end else begin
				want = mix_out_fifo.pop_front();
				checked_count++;
				if (result_ch.data.out_left !== want.out_left)
					flag_mismatch($sformatf("out_left got %0d expected %0d",
						$signed(result_ch.data.out_left), $signed(want.out_left)));
				if (result_ch.data.out_right !== want.out_right)
					flag_mismatch($sformatf("out_right got %0d expected %0d",
						$signed(result_ch.data.out_right), $signed(want.out_right)));
				if (result_ch.data.last_in_block !== want.last_in_block)
					flag_mismatch($sformatf("last_in_block got %b expected %b",
						result_ch.data.last_in_block, want.last_in_block));
				if (result_ch.data.accepted !== want.accepted)
					flag_mismatch($sformatf("accepted got %b expected %b",
						result_ch.data.accepted, want.accepted));
			end
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
		    (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("[%0t] no progress for %0d cycles", $realtime, idle_cycles);
			$display("FAIL stereo_volume_ramp_mixer_top");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.data  <= '0;
		for (int i = 0; i < GAIN_ENTRIES; i++)
			gain_tab[i] = '0;
		cur_vol   = '0;
		tgt_vol   = '0;
		ramp_left = '0;
		vol_step  = '0;
		audio_on  = 1'b0;
		src_idle_pct = 36;
		snk_idle_pct = 51;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_gain_table_load();
		test_audio_off();
		write_audio_present(1'b1);
		test_volume_jump();
		test_fade_clamps();
		test_reload_and_unused_kind();
		test_random_traffic(300);

		write_audio_present(1'b0);
		src_idle_pct = 51;
		snk_idle_pct = 36;
		test_random_traffic(60);
		write_audio_present(1'b1);
		test_random_traffic(250);

		drain_results();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_random_traffic(300);

		drain_results();
		if (mix_out_fifo.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", mix_out_fifo.size()));

		$display("Run covered %0d requests and %0d checked results, %0d fades taken,",
			req_count, checked_count, fades_taken);
		$display("%0d ramp steps and %0d saturated samples over three stall profiles.",
			ramp_steps, sat_count);
		if (err_count == 0)
			$display("PASS stereo_volume_ramp_mixer_top");
		else
			$display("FAIL stereo_volume_ramp_mixer_top");
		$finish;
	end

endmodule

/* files.f */
rtl/svrm_pkg.sv
rtl/svrm_if.sv
rtl/svrm_div.sv
rtl/stereo_volume_ramp_mixer_top.sv
rtl/svrm_checker.sv
verif/tb_stereo_volume_ramp_mixer_top.sv
